// File: design/gamepad_toggle_press_qualifier_macros.svh
// Assertion macros for the toggle press qualifier checker.
// No dependencies; included by the checker file only.
`ifndef GAMEPAD_TOGGLE_PRESS_QUALIFIER_MACROS_SVH
`define GAMEPAD_TOGGLE_PRESS_QUALIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GTPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gtpq assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define GTPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gtpq assertion failed");

`endif

// File: design/gtpq_pkg.sv
// Shared types, codes and reset values of the toggle press qualifier.
// No dependencies; used by gtpq_cfg_regs, gtpq_core and the top level.
package gtpq_pkg;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_DOUBLE = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_TOGGLE_CODE   = 3'd0,
    CFG_TOGGLE_MODE   = 3'd1,
    CFG_HOLD_TIME     = 3'd2,
    CFG_DOUBLE_WINDOW = 3'd3,
    CFG_TRIG_THRESH   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] CODE_NONE       = 16'd0;
  localparam logic [15:0] CODE_LEFT_TRIG  = 16'd9;
  localparam logic [15:0] CODE_RIGHT_TRIG = 16'd10;

  localparam logic [15:0] HOLD_TIME_RESET     = 16'd400;
  localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd300;
  localparam logic [7:0]  TRIG_THRESH_RESET   = 8'd128;

  typedef struct packed {
    logic [15:0] toggle_code;
    mode_e       toggle_mode;
    logic [15:0] hold_time_ms;
    logic [15:0] double_window_ms;
    logic [7:0]  trig_press_level;
  } cfg_t;

  typedef struct packed {
    logic        pad_connected;
    logic [15:0] button_bits;
    logic [7:0]  left_level;
    logic [7:0]  right_level;
    logic        menu_is_open;
    logic        any_window_open;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic        open_request;
    logic        close_request;
    logic [15:0] hotkey_edges;
    logic        left_press_event;
    logic        right_press_event;
  } result_t;

  // Only single mapped button bits select a button; anything else gives no mask.
  function automatic logic [15:0] code_to_mask(input logic [15:0] code);
    logic [15:0] mask;
    unique case (code)
      16'h0001, 16'h0002, 16'h0004, 16'h0008,
      16'h0010, 16'h0020, 16'h0040, 16'h0080,
      16'h0100, 16'h0200, 16'h1000, 16'h2000,
      16'h4000, 16'h8000: mask = code;
      default:            mask = 16'h0000;
    endcase
    return mask;
  endfunction

endpackage

// File: design/gtpq_cfg_regs.sv
// Configuration register file of the toggle press qualifier.
// Depends on gtpq_pkg.
module gtpq_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [gtpq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gtpq_pkg::CfgDataW-1:0]  cfg_data_i,
  output gtpq_pkg::cfg_t                 cfg_o
);

  gtpq_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (gtpq_pkg::cfg_idx_e'(cfg_index_i))
        gtpq_pkg::CFG_TOGGLE_CODE:   cfg_d.toggle_code      = cfg_data_i;
        gtpq_pkg::CFG_TOGGLE_MODE:   cfg_d.toggle_mode      = gtpq_pkg::mode_e'(cfg_data_i[1:0]);
        gtpq_pkg::CFG_HOLD_TIME:     cfg_d.hold_time_ms     = cfg_data_i;
        gtpq_pkg::CFG_DOUBLE_WINDOW: cfg_d.double_window_ms = cfg_data_i;
        gtpq_pkg::CFG_TRIG_THRESH:   cfg_d.trig_press_level = cfg_data_i[7:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.toggle_code      <= gtpq_pkg::CODE_NONE;
      cfg_q.toggle_mode      <= gtpq_pkg::MODE_SINGLE;
      cfg_q.hold_time_ms     <= gtpq_pkg::HOLD_TIME_RESET;
      cfg_q.double_window_ms <= gtpq_pkg::DOUBLE_WINDOW_RESET;
      cfg_q.trig_press_level <= gtpq_pkg::TRIG_THRESH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/gtpq_core.sv
// Per-sample qualifier: history, hold and double press state and result logic.
// Depends on gtpq_pkg.
module gtpq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  gtpq_pkg::sample_t sample_i,
  input  gtpq_pkg::cfg_t    cfg_i,
  output gtpq_pkg::result_t result_o
);

  logic [15:0] last_buttons_q, last_buttons_d;
  logic [7:0]  last_left_q, last_left_d;
  logic [7:0]  last_right_q, last_right_d;
  logic        hold_armed_q, hold_armed_d;
  logic [31:0] hold_start_q, hold_start_d;
  logic        awaiting_q, awaiting_d;
  logic [31:0] first_press_q, first_press_d;

  logic        cur_l_on, cur_r_on, lt_edge, rt_edge;
  logic [15:0] mask;
  logic        down, just, active;
  logic [31:0] hold_elapsed, gap;
  logic        hold_due, gap_ok;
  logic        open_rq, close_rq, report;

  always_comb begin
    cur_l_on = sample_i.left_level >= cfg_i.trig_press_level;
    cur_r_on = sample_i.right_level >= cfg_i.trig_press_level;
    lt_edge  = cur_l_on && (last_left_q < cfg_i.trig_press_level);
    rt_edge  = cur_r_on && (last_right_q < cfg_i.trig_press_level);
    mask     = gtpq_pkg::code_to_mask(cfg_i.toggle_code);

    priority if (cfg_i.toggle_code == gtpq_pkg::CODE_LEFT_TRIG) begin
      down = cur_l_on;
      just = lt_edge;
    end else if (cfg_i.toggle_code == gtpq_pkg::CODE_RIGHT_TRIG) begin
      down = cur_r_on;
      just = rt_edge;
    end else begin
      down = (sample_i.button_bits & mask) != 16'h0000;
      just = down && ((last_buttons_q & mask) == 16'h0000);
    end

    hold_elapsed = sample_i.now_ms - hold_start_q;
    gap          = sample_i.now_ms - first_press_q;
    hold_due     = hold_elapsed >= {16'h0000, cfg_i.hold_time_ms};
    gap_ok       = gap <= {16'h0000, cfg_i.double_window_ms};

    active = sample_i.pad_connected && (cfg_i.toggle_mode != gtpq_pkg::MODE_OFF)
             && (cfg_i.toggle_code != gtpq_pkg::CODE_NONE);

    hold_armed_d  = hold_armed_q;
    hold_start_d  = hold_start_q;
    awaiting_d    = awaiting_q;
    first_press_d = first_press_q;
    open_rq       = 1'b0;
    close_rq      = 1'b0;
    report        = 1'b0;

    if (active) begin
      if (sample_i.menu_is_open && just) begin
        close_rq = 1'b1;
      end else begin
        if (!sample_i.menu_is_open) begin
          unique case (cfg_i.toggle_mode)
            gtpq_pkg::MODE_SINGLE: begin
              open_rq = just;
            end
            gtpq_pkg::MODE_HOLD: begin
              priority if (just) begin
                hold_start_d = sample_i.now_ms;
                hold_armed_d = 1'b1;
              end else if (hold_armed_q && down) begin
                if (hold_due) begin
                  open_rq      = 1'b1;
                  hold_armed_d = 1'b0;
                end
              end else if (!down) begin
                hold_armed_d = 1'b0;
              end
            end
            default: begin
              // double press; the off mode never reaches here
              priority if (just) begin
                if (awaiting_q && gap_ok) begin
                  open_rq    = 1'b1;
                  awaiting_d = 1'b0;
                end else begin
                  first_press_d = sample_i.now_ms;
                  awaiting_d    = 1'b1;
                end
              end else if (awaiting_q && !gap_ok) begin
                awaiting_d = 1'b0;
              end
            end
          endcase
        end
        report = !sample_i.any_window_open;
      end
    end

    // a lost pad clears the history only
    if (sample_i.pad_connected) begin
      last_buttons_d = sample_i.button_bits;
      last_left_d    = sample_i.left_level;
      last_right_d   = sample_i.right_level;
    end else begin
      last_buttons_d = 16'h0000;
      last_left_d    = 8'h00;
      last_right_d   = 8'h00;
    end

    result_o.open_request      = open_rq;
    result_o.close_request     = close_rq;
    result_o.hotkey_edges      = report ? (sample_i.button_bits & ~last_buttons_q) : 16'h0000;
    result_o.left_press_event  = report && lt_edge;
    result_o.right_press_event = report && rt_edge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_buttons_q <= 16'h0000;
      last_left_q    <= 8'h00;
      last_right_q   <= 8'h00;
      hold_armed_q   <= 1'b0;
      hold_start_q   <= 32'h0000_0000;
      awaiting_q     <= 1'b0;
      first_press_q  <= 32'h0000_0000;
    end else if (step_i) begin
      last_buttons_q <= last_buttons_d;
      last_left_q    <= last_left_d;
      last_right_q   <= last_right_d;
      hold_armed_q   <= hold_armed_d;
      hold_start_q   <= hold_start_d;
      awaiting_q     <= awaiting_d;
      first_press_q  <= first_press_d;
    end
  end

endmodule

// File: design/gamepad_toggle_press_qualifier.sv
// Top level of the gamepad toggle press qualifier: input and result registers.
// Depends on gtpq_pkg, gtpq_cfg_regs and gtpq_core.
//
//   channel   direction  handshake                 payload
//   ------------------------------------------------------------------------
//   in        sink       in_valid_i / in_ready_o    pad sample fields
//   out       source     out_valid_o / out_ready_i  request and hotkey fields
//   cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transfer in gives exactly one result: it waits in the input register, then
// a step updates the qualifier state and loads the result register. One sample
// per cycle is sustained while out_ready_i is high. The critical path is the
// 32-bit elapsed-time subtract and compare. Reset clears the history and press
// state and loads the register reset values. A stalled result holds its register;
// the input register takes one more sample behind it, then in_ready_o drops.
module gamepad_toggle_press_qualifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           pad_connected_i,
  input  logic [15:0]                    button_bits_i,
  input  logic [7:0]                     left_level_i,
  input  logic [7:0]                     right_level_i,
  input  logic                           menu_is_open_i,
  input  logic                           any_window_open_i,
  input  logic [31:0]                    now_ms_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           open_request_o,
  output logic                           close_request_o,
  output logic [15:0]                    hotkey_edges_o,
  output logic                           left_press_event_o,
  output logic                           right_press_event_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gtpq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gtpq_pkg::CfgDataW-1:0]  cfg_data_i
);

  gtpq_pkg::cfg_t    cfg;
  gtpq_pkg::sample_t in_q;
  gtpq_pkg::result_t res_d, res_q;
  logic              in_valid_q, out_valid_q;
  logic              step;

  // Registers are always writable; the user must land writes only while idle.
  assign cfg_ready_o = 1'b1;

  gtpq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the held sample whenever the result register is free or draining.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  gtpq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // Input register: control bit under reset, payload loads on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.pad_connected   <= pad_connected_i;
      in_q.button_bits     <= button_bits_i;
      in_q.left_level      <= left_level_i;
      in_q.right_level     <= right_level_i;
      in_q.menu_is_open    <= menu_is_open_i;
      in_q.any_window_open <= any_window_open_i;
      in_q.now_ms          <= now_ms_i;
    end
  end

  // Result register: fill on a step, drop after the downstream transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign open_request_o      = res_q.open_request;
  assign close_request_o     = res_q.close_request;
  assign hotkey_edges_o      = res_q.hotkey_edges;
  assign left_press_event_o  = res_q.left_press_event;
  assign right_press_event_o = res_q.right_press_event;

endmodule

// File: design/gtpq_checker.sv
// Port-level checker for the toggle press qualifier, bound to the top level.
// Depends on gamepad_toggle_press_qualifier_macros.svh.
`include "gamepad_toggle_press_qualifier_macros.svh"

module gtpq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           open_request_o,
  input logic                           close_request_o,
  input logic [15:0]                    hotkey_edges_o,
  input logic                           left_press_event_o,
  input logic                           right_press_event_o
);

  logic [19:0] out_payload;
  assign out_payload = {open_request_o, close_request_o, hotkey_edges_o,
                        left_press_event_o, right_press_event_o};

  // open and close are decided on exclusive branches
  `GTPQ_ASSERT_NOW(a_open_close_excl, out_valid_o, !(open_request_o && close_request_o))

  // a close request suppresses the hotkey report
  `GTPQ_ASSERT_NOW(a_close_no_report, out_valid_o && close_request_o,
                   hotkey_edges_o == 16'h0000 && !left_press_event_o && !right_press_event_o)

  // a stalled result stays offered
  `GTPQ_ASSERT_NEXT(a_out_hold_valid, out_valid_o && !out_ready_i, out_valid_o)

  // a stalled result keeps its payload
  `GTPQ_ASSERT_NEXT(a_out_hold_data, out_valid_o && !out_ready_i, $stable(out_payload))

  // the sample side only stalls behind a stalled result
  `GTPQ_ASSERT_NOW(a_in_stall_full, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind gamepad_toggle_press_qualifier gtpq_checker u_gtpq_checker (.*);

// File: tb/gtpq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the toggle press qualifier: tracks register writes, predicts
// one result per accepted sample and compares results in order. Uses gtpq_pkg.
module gtpq_scoreboard
  import gtpq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                pad_connected_i,
  input  logic [15:0]         button_bits_i,
  input  logic [7:0]          left_level_i,
  input  logic [7:0]          right_level_i,
  input  logic                menu_is_open_i,
  input  logic                any_window_open_i,
  input  logic [31:0]         now_ms_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                open_request_i,
  input  logic                close_request_i,
  input  logic [15:0]         hotkey_edges_i,
  input  logic                left_press_event_i,
  input  logic                right_press_event_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         awaited_o
);

  cfg_t        regs;
  logic [15:0] seen_buttons;
  logic [7:0]  seen_left;
  logic [7:0]  seen_right;
  logic        hold_pending;
  logic [31:0] hold_origin;
  logic        second_pending;
  logic [31:0] first_origin;
  result_t     awaited_results[$];
  int unsigned result_no;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_no, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Advance the pad history and the toggle state by one sample.
  function automatic result_t qualify_sample(input sample_t s);
    result_t     r;
    logic [15:0] prev_b;
    logic [15:0] mask;
    logic [7:0]  prev_l;
    logic [7:0]  prev_r;
    logic [31:0] elapsed;
    logic [31:0] gap;
    logic        down;
    logic        just;
    logic        lt_cross;
    logic        rt_cross;
    logic        reported;
    r = '0;
    reported = 1'b0;
    if (!s.pad_connected) begin
      seen_buttons = '0;
      seen_left = '0;
      seen_right = '0;
      return r;
    end
    prev_b = seen_buttons;
    prev_l = seen_left;
    prev_r = seen_right;
    seen_buttons = s.button_bits;
    seen_left = s.left_level;
    seen_right = s.right_level;
    lt_cross = (s.left_level >= regs.trig_press_level) && (prev_l < regs.trig_press_level);
    rt_cross = (s.right_level >= regs.trig_press_level) && (prev_r < regs.trig_press_level);
    if (regs.toggle_mode != MODE_OFF && regs.toggle_code != CODE_NONE) begin
      if (regs.toggle_code == CODE_LEFT_TRIG) begin
        down = s.left_level >= regs.trig_press_level;
        just = lt_cross;
      end else if (regs.toggle_code == CODE_RIGHT_TRIG) begin
        down = s.right_level >= regs.trig_press_level;
        just = rt_cross;
      end else begin
        // a single bit selects a button, except bits 10 and 11
        mask = ((regs.toggle_code & (regs.toggle_code - 16'd1)) == 16'd0 &&
                (regs.toggle_code & 16'h0C00) == 16'd0) ? regs.toggle_code : 16'd0;
        down = (s.button_bits & mask) != 16'd0;
        just = down && ((prev_b & mask) == 16'd0);
      end
      if (s.menu_is_open && just) begin
        r.close_request = 1'b1;
      end else begin
        if (!s.menu_is_open) begin
          gap = s.now_ms - first_origin;
          case (regs.toggle_mode)
            MODE_SINGLE: begin
              r.open_request = just;
            end
            MODE_HOLD: begin
              elapsed = s.now_ms - hold_origin;
              if (just) begin
                hold_origin = s.now_ms;
                hold_pending = 1'b1;
              end else if (hold_pending && down) begin
                if (elapsed >= {16'd0, regs.hold_time_ms}) begin
                  r.open_request = 1'b1;
                  hold_pending = 1'b0;
                end
              end else if (!down) begin
                hold_pending = 1'b0;
              end
            end
            default: begin
              if (just) begin
                if (second_pending && gap <= {16'd0, regs.double_window_ms}) begin
                  r.open_request = 1'b1;
                  second_pending = 1'b0;
                end else begin
                  first_origin = s.now_ms;
                  second_pending = 1'b1;
                end
              end else if (second_pending && gap > {16'd0, regs.double_window_ms}) begin
                second_pending = 1'b0;
              end
            end
          endcase
        end
        reported = !s.any_window_open;
      end
    end
    if (reported) begin
      r.hotkey_edges = s.button_bits & ~prev_b;
      r.left_press_event = lt_cross;
      r.right_press_event = rt_cross;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sample_t s;
    result_t want;
    if (!rst_ni) begin
      regs.toggle_code = CODE_NONE;
      regs.toggle_mode = MODE_SINGLE;
      regs.hold_time_ms = HOLD_TIME_RESET;
      regs.double_window_ms = DOUBLE_WINDOW_RESET;
      regs.trig_press_level = TRIG_THRESH_RESET;
      seen_buttons = '0;
      seen_left = '0;
      seen_right = '0;
      hold_pending = 1'b0;
      hold_origin = '0;
      second_pending = 1'b0;
      first_origin = '0;
      awaited_results.delete();
      result_no = 0;
      fail_count_o = 0;
      awaited_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no sample outstanding");
        end else begin
          want = awaited_results.pop_front();
          check_field("open_request", 32'(open_request_i), 32'(want.open_request));
          check_field("close_request", 32'(close_request_i), 32'(want.close_request));
          check_field("hotkey_edges", 32'(hotkey_edges_i), 32'(want.hotkey_edges));
          check_field("left_press_event", 32'(left_press_event_i),
                      32'(want.left_press_event));
          check_field("right_press_event", 32'(right_press_event_i),
                      32'(want.right_press_event));
        end
        result_no++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TOGGLE_CODE:   regs.toggle_code = cfg_data_i;
          CFG_TOGGLE_MODE:   regs.toggle_mode = mode_e'(cfg_data_i[1:0]);
          CFG_HOLD_TIME:     regs.hold_time_ms = cfg_data_i;
          CFG_DOUBLE_WINDOW: regs.double_window_ms = cfg_data_i;
          CFG_TRIG_THRESH:   regs.trig_press_level = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        s.pad_connected = pad_connected_i;
        s.button_bits = button_bits_i;
        s.left_level = left_level_i;
        s.right_level = right_level_i;
        s.menu_is_open = menu_is_open_i;
        s.any_window_open = any_window_open_i;
        s.now_ms = now_ms_i;
        awaited_results.push_back(qualify_sample(s));
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the toggle press qualifier regression.
// Depends on gtpq_pkg, gamepad_toggle_press_qualifier and gtpq_scoreboard.
module tb_top;
  import gtpq_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                pad_connected;
  logic [15:0]         button_bits;
  logic [7:0]          left_level;
  logic [7:0]          right_level;
  logic                menu_is_open;
  logic                any_window_open;
  logic [31:0]         now_ms;
  logic                out_valid;
  logic                out_ready;
  logic                open_request;
  logic                close_request;
  logic [15:0]         hotkey_edges;
  logic                left_press_event;
  logic                right_press_event;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         fail_count;
  int unsigned         awaited;

  // Random idling on both channels; switched off for the final phase.
  bit                  idle_on = 1'b1;
  // Set by the stimulus to make the result side hold off for a long stretch.
  bit                  hold_off_req = 1'b0;
  // Running pad timestamp for the well-formed press sequences.
  logic [31:0]         pad_clock_ms = 32'd0;

  // Toggle control and mode of each random phase; phase 7 draws a random control.
  logic [15:0] phase_codes [11] = '{16'h0001, CODE_LEFT_TRIG, CODE_RIGHT_TRIG, 16'h8000,
                                    16'h0400, CODE_LEFT_TRIG, 16'h0200, 16'h0000,
                                    CODE_RIGHT_TRIG, 16'h1000, 16'h4000};
  mode_e       phase_modes [11] = '{MODE_HOLD, MODE_DOUBLE, MODE_HOLD, MODE_DOUBLE,
                                    MODE_SINGLE, MODE_HOLD, MODE_DOUBLE, MODE_SINGLE,
                                    MODE_DOUBLE, MODE_OFF, MODE_HOLD};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gamepad_toggle_press_qualifier uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .pad_connected_i     (pad_connected),
    .button_bits_i       (button_bits),
    .left_level_i        (left_level),
    .right_level_i       (right_level),
    .menu_is_open_i      (menu_is_open),
    .any_window_open_i   (any_window_open),
    .now_ms_i            (now_ms),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .open_request_o      (open_request),
    .close_request_o     (close_request),
    .hotkey_edges_o      (hotkey_edges),
    .left_press_event_o  (left_press_event),
    .right_press_event_o (right_press_event),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  gtpq_scoreboard u_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .pad_connected_i     (pad_connected),
    .button_bits_i       (button_bits),
    .left_level_i        (left_level),
    .right_level_i       (right_level),
    .menu_is_open_i      (menu_is_open),
    .any_window_open_i   (any_window_open),
    .now_ms_i            (now_ms),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .open_request_i      (open_request),
    .close_request_i     (close_request),
    .hotkey_edges_i      (hotkey_edges),
    .left_press_event_i  (left_press_event),
    .right_press_event_i (right_press_event),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .fail_count_o        (fail_count),
    .awaited_o           (awaited)
  );

  // Offer one pad sample and hold it until the transfer happens. Valid is only
  // dropped for an idle burst, never between back-to-back samples.
  task automatic offer(input logic c, input logic [15:0] b, input logic [7:0] l,
                       input logic [7:0] r, input logic menu, input logic gate,
                       input logic [31:0] t);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    pad_connected   <= c;
    button_bits     <= b;
    left_level      <= l;
    right_level     <= r;
    menu_is_open    <= menu;
    any_window_open <= gate;
    now_ms          <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding result has been taken, so
  // the block is idle before registers change.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  // One register write; valid is left high so that writes go back to back.
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reprogram every register from idle. Mode and threshold carry random upper
  // bits, which the block must ignore, and on noise[31] an unused index is hit.
  task automatic apply_setting(input logic [15:0] code, input mode_e mode,
                               input logic [15:0] hold, input logic [15:0] win,
                               input logic [7:0] thr);
    logic [31:0] noise;
    noise = $urandom;
    settle();
    put_reg(CFG_TOGGLE_CODE, code);
    put_reg(CFG_TOGGLE_MODE, {noise[13:0], mode});
    put_reg(CFG_HOLD_TIME, hold);
    put_reg(CFG_DOUBLE_WINDOW, win);
    put_reg(CFG_TRIG_THRESH, {noise[23:16], thr});
    if (noise[31]) begin
      put_reg(CFG_TRIG_THRESH + CfgIdxW'($urandom_range(1, 3)), noise[31:16]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Trigger level on the requested side of the threshold.
  function automatic logic [7:0] level_for(input logic down, input logic [7:0] thr);
    if (down) return 8'($urandom_range(thr, 255));
    if (thr == 8'd0) return 8'd0;
    return 8'($urandom_range(0, thr - 8'd1));
  endfunction

  // Mostly press and release sequences of the toggle control with timestamps
  // scaled to the hold time or double press window; a tenth is pure noise.
  task automatic run_phase(input int n, input logic [15:0] code, input mode_e mode,
                           input logic [15:0] hold, input logic [15:0] win,
                           input logic [7:0] thr, input int stall_at);
    int          i;
    int          base;
    logic        down;
    logic [15:0] b;
    logic [7:0]  l;
    logic [7:0]  r;
    logic [31:0] step;
    down = 1'b0;
    base = (mode == MODE_HOLD) ? int'(hold) : int'(win);
    for (i = 0; i < n; i++) begin
      if (i == stall_at) hold_off_req = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        offer(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        if ($urandom_range(0, 99) < 45) down = !down;
        case ($urandom_range(0, 9))
          0:       step = 32'd0;
          1:       step = $urandom;
          2, 3:    step = $urandom_range(0, 2 * base + 4);
          default: step = $urandom_range(0, base / 2 + 2);
        endcase
        pad_clock_ms += step;
        b = 16'($urandom);
        l = 8'($urandom);
        r = 8'($urandom);
        if (code == CODE_LEFT_TRIG) l = level_for(down, thr);
        else if (code == CODE_RIGHT_TRIG) r = level_for(down, thr);
        else b = down ? (b | code) : (b & ~code);
        offer($urandom_range(0, 99) >= 4, b, l, r, $urandom_range(0, 99) < 12,
              $urandom_range(0, 99) < 12, pad_clock_ms);
      end
    end
  endtask

  // Result side: ready bursts, idle bursts, and one long hold-off on request
  // so that the block fills and stalls the sample channel.
  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #800000;
    $display("gamepad_toggle_press_qualifier regression: fail");
    $finish;
  end

  initial begin : stimulus
    int          p;
    logic [15:0] code;
    logic [15:0] hold;
    logic [15:0] win;
    logic [7:0]  thr;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    pad_connected   <= 1'b0;
    button_bits     <= '0;
    left_level      <= '0;
    right_level     <= '0;
    menu_is_open    <= 1'b0;
    any_window_open <= 1'b0;
    now_ms          <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings select no toggle control, so even a full pad reports nothing.
    offer(1'b1, 16'hFFFF, 8'd255, 8'd255, 1'b0, 1'b0, 32'd0);

    // Single press on the top button bit, default timing and threshold.
    apply_setting(16'h8000, MODE_SINGLE, HOLD_TIME_RESET, DOUBLE_WINDOW_RESET,
                  TRIG_THRESH_RESET);
    offer(1'b1, 16'h0000, 8'd0,   8'd0,   1'b0, 1'b0, 32'd5);
    offer(1'b1, 16'hFFFF, 8'd255, 8'd255, 1'b0, 1'b0, 32'd6);   // open, every edge
    offer(1'b1, 16'hFFFF, 8'd255, 8'd255, 1'b0, 1'b0, 32'd7);   // no new edge
    offer(1'b1, 16'h0000, 8'd127, 8'd127, 1'b0, 1'b0, 32'd8);   // just under threshold
    offer(1'b1, 16'h8000, 8'd128, 8'd128, 1'b1, 1'b0, 32'd9);   // close, report skipped
    offer(1'b1, 16'h0001, 8'd0,   8'd0,   1'b1, 1'b0, 32'd10);  // menu open, no press
    offer(1'b1, 16'h0003, 8'd0,   8'd0,   1'b0, 1'b1, 32'd11);  // window gate
    offer(1'b0, 16'hFFFF, 8'd255, 8'd255, 1'b0, 1'b0, 32'd12);  // pad lost
    offer(1'b1, 16'h0001, 8'd200, 8'd0,   1'b0, 1'b0, 32'hFFFF_FFFF);

    // Hold on the left trigger: exact hold time, release, and a wrapped clock.
    apply_setting(CODE_LEFT_TRIG, MODE_HOLD, 16'd100, DOUBLE_WINDOW_RESET, 8'd200);
    offer(1'b1, 16'h0000, 8'd0,   8'd0, 1'b0, 1'b0, 32'd990);
    offer(1'b1, 16'h0000, 8'd200, 8'd0, 1'b0, 1'b0, 32'd1000);  // arm
    offer(1'b1, 16'h0000, 8'd255, 8'd0, 1'b0, 1'b0, 32'd1050);
    offer(1'b1, 16'h0000, 8'd210, 8'd0, 1'b0, 1'b0, 32'd1100);  // open on the boundary
    offer(1'b1, 16'h0000, 8'd220, 8'd0, 1'b0, 1'b0, 32'd1200);  // already disarmed
    offer(1'b1, 16'h0000, 8'd0,   8'd0, 1'b0, 1'b0, 32'd1300);
    offer(1'b1, 16'h0000, 8'd200, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFF0);
    offer(1'b1, 16'h0000, 8'd201, 8'd0, 1'b0, 1'b0, 32'h0000_0060);

    // Double press on the right trigger: inside the window, too late, expiry.
    apply_setting(CODE_RIGHT_TRIG, MODE_DOUBLE, 16'd100, 16'd50, TRIG_THRESH_RESET);
    offer(1'b1, 16'h0000, 8'd0, 8'd255, 1'b0, 1'b0, 32'd10);    // first press
    offer(1'b1, 16'h0000, 8'd0, 8'd0,   1'b0, 1'b0, 32'd20);
    offer(1'b1, 16'h0000, 8'd0, 8'd255, 1'b0, 1'b0, 32'd60);    // gap equals window
    offer(1'b1, 16'h0000, 8'd0, 8'd0,   1'b0, 1'b0, 32'd70);
    offer(1'b1, 16'h0000, 8'd0, 8'd255, 1'b0, 1'b0, 32'd80);
    offer(1'b1, 16'h0000, 8'd0, 8'd0,   1'b0, 1'b0, 32'd90);
    offer(1'b1, 16'h0000, 8'd0, 8'd255, 1'b0, 1'b0, 32'd200);   // late, restarts
    offer(1'b1, 16'h0000, 8'd0, 8'd0,   1'b0, 1'b0, 32'd400);   // wait expires

    // Random phases: low extremes first, high extremes next, then random
    // timing. The third phase carries the long result hold-off; the last
    // phase runs without any idling.
    for (p = 0; p < 11; p++) begin
      code = (p == 7) ? 16'($urandom) : phase_codes[p];
      case (p)
        0: begin
          hold = 16'd0;
          win  = 16'd0;
          thr  = 8'd0;
        end
        1: begin
          hold = 16'hFFFF;
          win  = 16'hFFFF;
          thr  = 8'hFF;
        end
        default: begin
          hold = 16'($urandom_range(10, 600));
          win  = 16'($urandom_range(10, 600));
          thr  = 8'($urandom_range(1, 254));
        end
      endcase
      if (p == 10) idle_on = 1'b0;
      apply_setting(code, phase_modes[p], hold, win, thr);
      run_phase(84, code, phase_modes[p], hold, win, thr, (p == 2) ? 30 : -1);
    end

    // Drain, let the pipeline go quiet, then give the verdict.
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("gamepad_toggle_press_qualifier regression: pass");
    end else begin
      $display("gamepad_toggle_press_qualifier regression: fail");
    end
    $finish;
  end

endmodule

// File: gamepad_toggle_press_qualifier.f
+incdir+design
design/gtpq_pkg.sv
design/gtpq_cfg_regs.sv
design/gtpq_core.sv
design/gamepad_toggle_press_qualifier.sv
design/gtpq_checker.sv
tb/gtpq_checker.sv
tb/tb_top.sv
